[hdl/pfp_pkg.sv]
// Shared types and constants for the packet fragment planner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pfp_pkg;

  // field widths
  localparam int LEN_W          = 16;
  localparam int HDR_W          = 32;
  localparam int SEQ_W          = 8;
  localparam int IDX_FIELD_W    = 5;
  localparam int SIZE_FIELD_W   = 14;
  localparam int TYPE_FIELD_W   = 2;
  localparam int HDR_PAD_W      = HDR_W - SIZE_FIELD_W - IDX_FIELD_W - SEQ_W - TYPE_FIELD_W;

  // defaults
  localparam logic [LEN_W-1:0] CFG_MAX_SIZE_RESET = 16'd1400;
  localparam int               MAX_FRAGMENTS_DEF  = 32;

  // fragment type codes in the header
  typedef enum logic [TYPE_FIELD_W-1:0] {
    HDR_WHOLE    = 2'd0,
    HDR_NOT_LAST = 2'd1,
    HDR_LAST     = 2'd2
  } frag_type_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_DIV_MAIN,
    OP_TAKE_MAIN,
    OP_DIV_ADJ,
    OP_TAKE_ADJ,
    OP_USE_ALIGNED,
    OP_LIMIT,
    OP_START_RUN,
    OP_OUT_WHOLE,
    OP_OUT_ERROR,
    OP_OUT_FRAG
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic short_pkt;
    logic aligned_zero;
    logic shrink;
    logic too_many;
    logic fits_one;
    logic div_done;
    logic out_free;
    logic last_frag;
  } dp_status_t;

endpackage

[hdl/pfp_if.sv]
// Handshake channels of the packet fragment planner: packet lengths in,
// fragment results out. Depends on pfp_pkg for the field widths.
`timescale 1ns / 1ps

interface pfp_in_if;
  import pfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] packet_length;

  modport source (output valid, output packet_length, input ready);
  modport sink   (input valid, input packet_length, output ready);
endinterface

interface pfp_out_if;
  import pfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [HDR_W-1:0] header_word;
  logic [LEN_W-1:0] fragment_offset;
  logic [LEN_W-1:0] fragment_length;
  logic             last_of_run;
  logic             status;

  modport source (output valid, output header_word, output fragment_offset,
                  output fragment_length, output last_of_run, output status,
                  input ready);
  modport sink   (input valid, input header_word, input fragment_offset,
                  input fragment_length, input last_of_run, input status,
                  output ready);
endinterface

[hdl/pfp_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on pfp_pkg for the operand width.
`timescale 1ns / 1ps

module pfp_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [pfp_pkg::LEN_W-1:0] dividend,
  input  logic [pfp_pkg::LEN_W-1:0] divisor,
  output logic                 done,
  output logic [pfp_pkg::LEN_W-1:0] quotient,
  output logic [pfp_pkg::LEN_W-1:0] remainder
);
  import pfp_pkg::*;

  localparam int CntW = $clog2(LEN_W + 1);

  logic [LEN_W-1:0] part_r, part_nxt;
  logic [LEN_W-1:0] quo_r, quo_nxt;
  logic [LEN_W-1:0] div_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   trial;

  // one restoring step
  always_comb begin
    shifted = {part_r, quo_r[LEN_W-1]};
    trial   = shifted - {1'b0, div_r};
    if (shifted >= {1'b0, div_r}) begin
      part_nxt = trial[LEN_W-1:0];
      quo_nxt  = {quo_r[LEN_W-2:0], 1'b1};
    end else begin
      part_nxt = shifted[LEN_W-1:0];
      quo_nxt  = {quo_r[LEN_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(LEN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      part_r <= '0;
      quo_r  <= dividend;
      div_r  <= divisor;
    end else if (busy_r) begin
      part_r <= part_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = part_r;

endmodule

[hdl/pfp_datapath.sv]
// Datapath: configuration register, size planning registers, fragment
// walk and the output register. Depends on pfp_pkg and pfp_divider.
`timescale 1ns / 1ps

module pfp_datapath #(
  parameter int MAX_FRAGMENTS = pfp_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pfp_pkg::LEN_W-1:0]     cfg_wr_data,
  input  logic [pfp_pkg::LEN_W-1:0]     in_packet_length,
  input  pfp_pkg::dp_op_t               op,
  output pfp_pkg::dp_status_t           stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfp_pkg::HDR_W-1:0]     out_header_word,
  output logic [pfp_pkg::LEN_W-1:0]     out_fragment_offset,
  output logic [pfp_pkg::LEN_W-1:0]     out_fragment_length,
  output logic                          out_last_of_run,
  output logic                          out_status
);
  import pfp_pkg::*;

  localparam int IdxW = $clog2(MAX_FRAGMENTS);
  localparam int LimW = LEN_W + $clog2(MAX_FRAGMENTS + 1);

  logic [LEN_W-1:0] max_size_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] cnt_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] fsz_r;
  logic [LimW-1:0]  lim_r;
  logic [LEN_W-1:0] off_r;
  logic [IdxW-1:0]  idx_r;
  logic [SEQ_W-1:0] seq_r;

  logic             out_valid_r;
  logic [HDR_W-1:0] hdr_r;
  logic [LEN_W-1:0] out_off_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_last_r;
  logic             out_stat_r;

  logic [LEN_W-1:0] aligned;
  logic [LEN_W-1:0] three_quarters;
  logic             div_start;
  logic [LEN_W-1:0] div_num;
  logic [LEN_W-1:0] div_den;
  logic             div_done;
  logic [LEN_W-1:0] div_quo;
  logic [LEN_W-1:0] div_rem;
  logic [LEN_W:0]   cand;
  logic [LEN_W-1:0] cand_fsz;
  logic [LEN_W-1:0] remain;
  logic             last_frag;
  logic [LEN_W-1:0] piece;
  logic [HDR_W-1:0] frag_hdr;
  logic             out_free;

  // aligned size and the shrink threshold
  assign aligned        = {max_size_r[LEN_W-1:2], 2'b00};
  assign three_quarters = aligned - {2'b00, aligned[LEN_W-1:2]};

  // divider operand select: main split or balance correction
  assign div_start = (op == OP_DIV_MAIN) || (op == OP_DIV_ADJ);
  assign div_num   = (op == OP_DIV_ADJ) ? (max_size_r - rem_r) : len_r;
  assign div_den   = (op == OP_DIV_ADJ) ? (cnt_r + 16'd1) : aligned;

  pfp_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // balanced candidate, rounded up to 4 and capped at the aligned size
  always_comb begin
    cand = ({1'b0, max_size_r} - {1'b0, div_quo} + 17'd3) & ~17'd3;
    if (cand < {1'b0, aligned}) begin
      cand_fsz = cand[LEN_W-1:0];
    end else begin
      cand_fsz = aligned;
    end
  end

  // current fragment of the run
  assign remain    = len_r - off_r;
  assign last_frag = (remain <= fsz_r);
  assign piece     = last_frag ? remain : fsz_r;

  always_comb begin
    frag_hdr = {
      {HDR_PAD_W{1'b0}},
      last_frag ? fsz_r[LEN_W-1:2] : {SIZE_FIELD_W{1'b0}},
      IDX_FIELD_W'(idx_r),
      seq_r,
      last_frag ? HDR_LAST : HDR_NOT_LAST
    };
  end

  assign out_free = !out_valid_r || out_ready;

  // status to the controller
  always_comb begin
    stat.short_pkt    = (len_r < max_size_r);
    stat.aligned_zero = (max_size_r[LEN_W-1:2] == '0);
    stat.shrink       = (cnt_r != '0) && (rem_r != '0) && (rem_r < three_quarters);
    stat.too_many     = ({{(LimW-LEN_W){1'b0}}, len_r} > lim_r);
    stat.fits_one     = (len_r <= fsz_r);
    stat.div_done     = div_done;
    stat.out_free     = out_free;
    stat.last_frag    = last_frag;
  end

  // control registers: configuration, sequence counter, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r  <= CFG_MAX_SIZE_RESET;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_size_r <= cfg_wr_data;
      end
      if (op == OP_START_RUN) begin
        seq_r <= seq_r + 1'b1;
      end
      if (op == OP_OUT_WHOLE || op == OP_OUT_ERROR || op == OP_OUT_FRAG) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // planning and output payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_CAPTURE: begin
        len_r <= in_packet_length;
      end
      OP_TAKE_MAIN: begin
        cnt_r <= div_quo;
        rem_r <= div_rem;
      end
      OP_TAKE_ADJ: begin
        fsz_r <= cand_fsz;
      end
      OP_USE_ALIGNED: begin
        fsz_r <= aligned;
      end
      OP_LIMIT: begin
        lim_r <= LimW'(fsz_r) * LimW'(MAX_FRAGMENTS);
      end
      OP_START_RUN: begin
        off_r <= '0;
        idx_r <= '0;
      end
      OP_OUT_WHOLE: begin
        hdr_r      <= '0;
        out_off_r  <= '0;
        out_len_r  <= len_r;
        out_last_r <= 1'b1;
        out_stat_r <= 1'b0;
      end
      OP_OUT_ERROR: begin
        hdr_r      <= '0;
        out_off_r  <= '0;
        out_len_r  <= '0;
        out_last_r <= 1'b1;
        out_stat_r <= 1'b1;
      end
      OP_OUT_FRAG: begin
        hdr_r      <= frag_hdr;
        out_off_r  <= off_r;
        out_len_r  <= piece;
        out_last_r <= last_frag;
        out_stat_r <= 1'b0;
        off_r      <= off_r + piece;
        idx_r      <= idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_header_word     = hdr_r;
  assign out_fragment_offset = out_off_r;
  assign out_fragment_length = out_len_r;
  assign out_last_of_run     = out_last_r;
  assign out_status          = out_stat_r;

endmodule

[hdl/pfp_ctrl.sv]
// Controller state machine: sequences classification, the two divisions,
// the limit check and the fragment walk. Depends on pfp_pkg.
`timescale 1ns / 1ps

module pfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfp_pkg::dp_status_t stat,
  output pfp_pkg::dp_op_t     op
);
  import pfp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_DIV_MAIN,
    S_ADJUST,
    S_DIV_ADJ,
    S_LIMIT,
    S_CHECK,
    S_OUT_WHOLE,
    S_OUT_ERROR,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_CAPTURE;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (stat.short_pkt) begin
          state_nxt = S_OUT_WHOLE;
        end else if (stat.aligned_zero) begin
          state_nxt = S_OUT_ERROR;
        end else begin
          op        = OP_DIV_MAIN;
          state_nxt = S_DIV_MAIN;
        end
      end
      S_DIV_MAIN: begin
        if (stat.div_done) begin
          op        = OP_TAKE_MAIN;
          state_nxt = S_ADJUST;
        end
      end
      S_ADJUST: begin
        if (stat.shrink) begin
          op        = OP_DIV_ADJ;
          state_nxt = S_DIV_ADJ;
        end else begin
          op        = OP_USE_ALIGNED;
          state_nxt = S_LIMIT;
        end
      end
      S_DIV_ADJ: begin
        if (stat.div_done) begin
          op        = OP_TAKE_ADJ;
          state_nxt = S_LIMIT;
        end
      end
      S_LIMIT: begin
        op        = OP_LIMIT;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.too_many) begin
          state_nxt = S_OUT_ERROR;
        end else if (stat.fits_one) begin
          state_nxt = S_OUT_WHOLE;
        end else begin
          op        = OP_START_RUN;
          state_nxt = S_EMIT;
        end
      end
      S_OUT_WHOLE: begin
        if (stat.out_free) begin
          op        = OP_OUT_WHOLE;
          state_nxt = S_IDLE;
        end
      end
      S_OUT_ERROR: begin
        if (stat.out_free) begin
          op        = OP_OUT_ERROR;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          op = OP_OUT_FRAG;
          if (stat.last_frag) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

[hdl/packet_fragment_planner_core.sv]
// Top level of the packet fragment planner: controller plus datapath.
// Depends on pfp_pkg, pfp_if, pfp_ctrl and pfp_datapath.
//
// Usage:
//   in_ch carries one packet length per item (valid/ready). out_ch gives
//   one item per fragment: header word, offset, length, last mark and
//   status; last_of_run marks the final item of each packet.
//   cfg_wr_en/cfg_wr_data write max_fragment_size; write only while idle.
// Flow:
//   A packet below the maximum, or one rejected at classification, goes
//   straight to the output register without a division. Other packets go
//   through the shared divider once, or twice when the size is rebalanced;
//   their fragments then follow one fragment per cycle while out_ch is ready.
//   One packet is worked on at a time; the next length is accepted once the
//   last result sits in the output register.
// Reset:
//   synchronous, active low; max_fragment_size returns to 1400 and the
//   sequence counter to zero. No result is pending after reset.
// Stalls:
//   while out_ch is not ready the result holds and the fragment walk waits.
`timescale 1ns / 1ps

module packet_fragment_planner_core #(
  parameter int MAX_FRAGMENTS = pfp_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [pfp_pkg::LEN_W-1:0] cfg_wr_data,
  pfp_in_if.sink                    in_ch,
  pfp_out_if.source                 out_ch
);
  import pfp_pkg::*;

  dp_op_t     op;
  dp_status_t stat;
  logic       ready;

  // sequencing
  pfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .op       (op)
  );

  assign in_ch.ready = ready;

  // arithmetic and output staging
  pfp_datapath #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_packet_length    (in_ch.packet_length),
    .op                  (op),
    .stat                (stat),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_header_word     (out_ch.header_word),
    .out_fragment_offset (out_ch.fragment_offset),
    .out_fragment_length (out_ch.fragment_length),
    .out_last_of_run     (out_ch.last_of_run),
    .out_status          (out_ch.status)
  );

endmodule
